@@ rtl/dws_pkg.sv @@
// Shared types and constants for the DAC I2C write sequencer.
// No dependencies; used by dws_seq_core and dac_i2c_write_sequencer_unit.
`default_nettype none

package dws_pkg;

	localparam int PhaseW = 7;
	localparam int FrameW = 24;

	// phase indexes of the 88-phase write
	localparam logic [PhaseW-1:0] PhStartData   = 7'd0;
	localparam logic [PhaseW-1:0] PhStartClk    = 7'd1;
	localparam logic [PhaseW-1:0] PhStartLow    = 7'd2;
	localparam logic [PhaseW-1:0] PhBodyFirst   = 7'd3;
	localparam logic [PhaseW-1:0] PhStopClkLow  = 7'd84;
	localparam logic [PhaseW-1:0] PhStopDataLow = 7'd85;
	localparam logic [PhaseW-1:0] PhStopClkHigh = 7'd86;
	localparam logic [PhaseW-1:0] PhLast        = 7'd87;

	// step within one bit slot
	localparam logic [1:0] SubClkLow  = 2'd0;
	localparam logic [1:0] SubData    = 2'd1;
	localparam logic [1:0] SubClkHigh = 2'd2;

	// slot within a byte: 0..7 data bits, then the ACK slot
	localparam logic [3:0] SlotAck = 4'd8;

	localparam logic [7:0] AdrBase = 8'h40;
	localparam logic [7:0] InsBase = 8'hF0;

	localparam logic [2:0] SubaddrReset = 3'd4;

	typedef struct packed {
		logic clock_line;
		logic data_line;
		logic busy;
		logic seq_end;
		logic refused;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/dws_seq_core.sv @@
// Phase sequencer: phase counter, frame shift register and line levels.
// Depends on dws_pkg. Advances one phase per accepted transaction while busy or on a start.
`default_nettype none

module dws_seq_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic            op,
	input  wire logic [2:0]      dac_channel,
	input  wire logic [7:0]      dac_value,
	input  wire logic [2:0]      chip_subaddress,
	output dws_pkg::result_t     res
);

	logic [dws_pkg::PhaseW-1:0] phase_q, phase_n;
	logic [dws_pkg::FrameW-1:0] shift_q, shift_n, shift_src;
	logic [1:0]                 sub_q, sub_n;
	logic [3:0]                 slot_q, slot_n;
	logic                       clk_q, clk_n;
	logic                       dat_q, dat_n;
	logic                       busy, active;
	logic [7:0]                 adr_byte, ins_byte;

	assign busy     = (phase_q != '0);
	assign active   = busy | op;
	assign adr_byte = dws_pkg::AdrBase | {4'd0, chip_subaddress, 1'b0};
	assign ins_byte = dws_pkg::InsBase | {5'd0, dac_channel};
	assign shift_src = busy ? shift_q : {adr_byte, ins_byte, dac_value};

	always_comb begin
		phase_n = phase_q;
		shift_n = shift_q;
		sub_n   = sub_q;
		slot_n  = slot_q;
		clk_n   = clk_q;
		dat_n   = dat_q;
		if (active) begin
			shift_n = shift_src;
			if (phase_q == dws_pkg::PhLast) begin
				phase_n = '0;
			end else begin
				phase_n = phase_q + 7'd1;
			end
			if (phase_q < dws_pkg::PhBodyFirst) begin
				if (phase_q == dws_pkg::PhStartData) begin
					dat_n = 1'b1;
				end else if (phase_q == dws_pkg::PhStartClk) begin
					clk_n = 1'b1;
				end else begin
					dat_n = 1'b0;
				end
			end else if (phase_q < dws_pkg::PhStopClkLow) begin
				case (sub_q)
					dws_pkg::SubClkLow: begin
						clk_n = 1'b0;
						sub_n = dws_pkg::SubData;
					end
					dws_pkg::SubData: begin
						if (slot_q == dws_pkg::SlotAck) begin
							dat_n = 1'b1;   // released, ACK not sampled
						end else begin
							dat_n   = shift_src[dws_pkg::FrameW-1];
							shift_n = {shift_src[dws_pkg::FrameW-2:0], 1'b0};
						end
						sub_n = dws_pkg::SubClkHigh;
					end
					default: begin
						clk_n  = 1'b1;
						sub_n  = dws_pkg::SubClkLow;
						slot_n = (slot_q == dws_pkg::SlotAck) ? 4'd0 : slot_q + 4'd1;
					end
				endcase
			end else if (phase_q == dws_pkg::PhStopClkLow) begin
				clk_n = 1'b0;
			end else if (phase_q == dws_pkg::PhStopDataLow) begin
				dat_n = 1'b0;
			end else if (phase_q == dws_pkg::PhStopClkHigh) begin
				clk_n = 1'b1;
			end else begin
				dat_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			shift_q <= '0;
			sub_q   <= dws_pkg::SubClkLow;
			slot_q  <= '0;
			clk_q   <= 1'b0;
			dat_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			shift_q <= shift_n;
			sub_q   <= sub_n;
			slot_q  <= slot_n;
			clk_q   <= clk_n;
			dat_q   <= dat_n;
		end
	end

	assign res.clock_line = clk_n;
	assign res.data_line  = dat_n;
	assign res.busy       = (phase_n != '0);
	assign res.seq_end    = active && (phase_q == dws_pkg::PhLast);
	assign res.refused    = busy & op;

	// bit-slot counters are back at rest whenever the sequencer is idle
	a_idle_slots: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == '0) |-> (sub_q == dws_pkg::SubClkLow && slot_q == 4'd0))
		else $error("slot counters not at rest while idle");
	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		(sub_q != 2'd3) && (slot_q <= dws_pkg::SlotAck))
		else $error("slot counter out of range");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= dws_pkg::PhLast)
		else $error("phase counter out of range");

endmodule

`default_nettype wire

@@ rtl/dac_i2c_write_sequencer_unit.sv @@
// DAC I2C write sequencer, top level: config register, sequencer, output skid.
// Depends on dws_pkg and dws_seq_core.
//
// Usage:
//   Input channel (in_valid/in_stall, op, dac_channel, dac_value): op=1 starts
//   a three-byte write to one DAC channel, op=0 is a tick advancing one line
//   phase while busy. A full write takes 88 transactions, the start counting as the first.
//   A start while busy is refused (start_refused=1) and acts as a tick.
//   Output channel (out_valid/out_stall): exactly one result per input
//   transaction: clock_line/data_line levels, busy_res, sequence_end on the
//   final stop phase, start_refused.
//   Each result is registered into the output register, or into the skid register
//   while the output register holds an untaken one; one transaction per cycle is sustained while out_stall stays low.
//   An output register plus a one-entry skid register part the channels, so
//   input is taken while a result waits; in_stall rises only once both hold
//   results, and nothing is lost or repeated while the receiver stalls.
//   cfg_write_en/cfg_write_data write chip_subaddress (reset 4); write it only
//   while idle, it is used at the next start.
//   Reset (arst_n low) clears the sequencer to idle with both lines low and
//   empties the output stages.
`default_nettype none

module dac_i2c_write_sequencer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write_en,
	input  wire logic [2:0] cfg_write_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       op,
	input  wire logic [2:0] dac_channel,
	input  wire logic [7:0] dac_value,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            clock_line,
	output logic            data_line,
	output logic            busy_res,
	output logic            sequence_end,
	output logic            start_refused
);

	logic [2:0]        subaddr_q;
	logic              accept, take;
	dws_pkg::result_t  res;
	dws_pkg::result_t  out_res_q, skid_res_q;
	logic              out_valid_q, skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subaddr_q <= dws_pkg::SubaddrReset;
		end else if (cfg_write_en) begin
			subaddr_q <= cfg_write_data;
		end
	end

	assign accept = in_valid & ~skid_valid_q;
	assign take   = out_valid_q & ~out_stall;

	dws_seq_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (accept),
		.op              (op),
		.dac_channel     (dac_channel),
		.dac_value       (dac_value),
		.chip_subaddress (subaddr_q),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_res_q <= skid_res_q;
			end
		end else if (accept) begin
			if (!out_valid_q || take) begin
				out_res_q <= res;
			end else begin
				skid_res_q <= res;
			end
		end
	end

	assign in_stall      = skid_valid_q;
	assign out_valid     = out_valid_q;
	assign clock_line    = out_res_q.clock_line;
	assign data_line     = out_res_q.data_line;
	assign busy_res      = out_res_q.busy;
	assign sequence_end  = out_res_q.seq_end;
	assign start_refused = out_res_q.refused;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a transaction with output register empty");
	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!skid_valid_q && accept && out_valid_q && out_stall) |=> skid_valid_q)
		else $error("transaction lost while output stalled");
	a_end_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_res_q.seq_end) |-> !out_res_q.busy)
		else $error("sequence end reported while still busy");

endmodule

`default_nettype wire

@@ dv/dws_line_checker.sv @@
// Line-level checker for the DAC I2C write sequencer: watches both channels and the config port.
// Keeps its own phase/frame model, queues expected line states and compares each result.
// Depends on dws_pkg.
`timescale 1ns / 100ps

module dws_line_checker
	import dws_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write_en,
	input  wire logic [2:0] cfg_write_data,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic       op,
	input  wire logic [2:0] dac_channel,
	input  wire logic [7:0] dac_value,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic       clock_line,
	input  wire logic       data_line,
	input  wire logic       busy_res,
	input  wire logic       sequence_end,
	input  wire logic       start_refused,
	output int              mismatch_count,
	output int              pending_count
);

	localparam int ByteSteps = 3 * (int'(SlotAck) + 1);

	logic [PhaseW-1:0] next_phase;
	logic [FrameW-1:0] frame_bits;
	logic              scl_level;
	logic              sda_level;
	logic [2:0]        chip_addr;
	result_t           expected_lines[$];

	// line update for one phase of the write
	task automatic drive_phase(input logic [PhaseW-1:0] ph);
		int step_idx;
		if (ph < PhBodyFirst) begin
			case (ph)
				PhStartData: sda_level = 1'b1;
				PhStartClk:  scl_level = 1'b1;
				default:     sda_level = 1'b0;
			endcase
		end else if (ph < PhStopClkLow) begin
			step_idx = (int'(ph) - int'(PhBodyFirst)) % ByteSteps;
			case (step_idx % 3)
				SubClkLow:  scl_level = 1'b0;
				SubClkHigh: scl_level = 1'b1;
				default: begin
					if (step_idx / 3 < int'(SlotAck)) begin
						sda_level  = frame_bits[FrameW-1];
						frame_bits = frame_bits << 1;
					end else begin
						sda_level = 1'b1; // ack slot, line released
					end
				end
			endcase
		end else begin
			case (ph)
				PhStopClkLow:  scl_level = 1'b0;
				PhStopDataLow: sda_level = 1'b0;
				PhStopClkHigh: scl_level = 1'b1;
				default:       sda_level = 1'b1;
			endcase
		end
	endtask

	task automatic advance_lines(input logic start_req, input logic [2:0] chan,
			input logic [7:0] level, output result_t res);
		logic              active;
		logic [PhaseW-1:0] ph;
		res    = '0;
		active = 1'b0;
		if (next_phase == '0) begin
			if (start_req) begin
				frame_bits = {AdrBase | {4'd0, chip_addr, 1'b0}, InsBase | {5'd0, chan}, level};
				active     = 1'b1;
			end
		end else begin
			res.refused = start_req;
			active      = 1'b1;
		end
		if (active) begin
			ph = (next_phase > PhLast) ? PhLast : next_phase;
			drive_phase(ph);
			if (ph == PhLast) begin
				next_phase  = '0;
				res.seq_end = 1'b1;
			end else begin
				next_phase = ph + 1'b1;
			end
		end
		res.clock_line = scl_level;
		res.data_line  = sda_level;
		res.busy       = (next_phase != '0);
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		result_t seen;
		result_t oldest;
		result_t predicted;
		if (!arst_n) begin
			next_phase = '0;
			frame_bits = '0;
			scl_level  = 1'b0;
			sda_level  = 1'b0;
			chip_addr  = SubaddrReset;
			expected_lines.delete();
			mismatch_count = 0;
			pending_count  = 0;
		end else begin
			// check results first so a same-edge push cannot hide a pass-through
			if (out_valid && !out_stall) begin
				seen = '{clock_line, data_line, busy_res, sequence_end, start_refused};
				if (expected_lines.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected transaction: got scl=%b sda=%b busy=%b end=%b ref=%b",
							$realtime, seen.clock_line, seen.data_line, seen.busy,
							seen.seq_end, seen.refused);
				end else begin
					oldest = expected_lines.pop_front();
					if (seen.clock_line !== oldest.clock_line || seen.data_line !== oldest.data_line ||
							seen.busy !== oldest.busy || seen.seq_end !== oldest.seq_end ||
							seen.refused !== oldest.refused) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: mismatch: exp scl=%b sda=%b busy=%b end=%b ref=%b, got scl=%b sda=%b busy=%b end=%b ref=%b",
								$realtime, oldest.clock_line, oldest.data_line, oldest.busy,
								oldest.seq_end, oldest.refused, seen.clock_line, seen.data_line,
								seen.busy, seen.seq_end, seen.refused);
					end
				end
			end
			if (cfg_write_en)
				chip_addr = cfg_write_data;
			if (in_valid && !in_stall) begin
				advance_lines(op, dac_channel, dac_value, predicted);
				expected_lines.push_back(predicted);
			end
			pending_count = expected_lines.size();
		end
	end

endmodule

@@ dv/dac_i2c_write_sequencer_unit_tb.sv @@
// Testbench top for dac_i2c_write_sequencer_unit: clock, reset, stimulus and verdict.
// Drives full channel writes with random stalls; dws_line_checker does the comparing.
// Depends on dws_pkg, dws_line_checker and the RTL.
`timescale 1ns / 100ps

module dac_i2c_write_sequencer_unit_tb;
	import dws_pkg::*;

	localparam logic OpTick      = 1'b0;
	localparam logic OpStart     = 1'b1;
	localparam int   WritePhases = int'(PhLast) + 1;
	localparam int   ItemTarget  = 1750;
	localparam int   CfgPhases   = 5;
	localparam int   DrainCycles = 8;
	localparam int   CycleLimit  = 400000;

	logic       clk            = 1'b0;
	logic       arst_n         = 1'b0;
	logic       cfg_write_en   = 1'b0;
	logic [2:0] cfg_write_data = '0;
	logic       in_valid       = 1'b0;
	logic       op             = OpTick;
	logic [2:0] dac_channel    = '0;
	logic [7:0] dac_value      = '0;
	logic       out_stall      = 1'b0;
	wire logic  in_stall;
	wire logic  out_valid;
	wire logic  clock_line;
	wire logic  data_line;
	wire logic  busy_res;
	wire logic  sequence_end;
	wire logic  start_refused;

	int   mismatches;
	int   outstanding;
	int   items_sent  = 0;
	int   cycle_count = 0;
	logic send_calm   = 1'b0;
	logic recv_calm   = 1'b0;

	dac_i2c_write_sequencer_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.dac_channel   (dac_channel),
		.dac_value     (dac_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.clock_line    (clock_line),
		.data_line     (data_line),
		.busy_res      (busy_res),
		.sequence_end  (sequence_end),
		.start_refused (start_refused)
	);

	dws_line_checker line_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.dac_channel   (dac_channel),
		.dac_value     (dac_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.clock_line    (clock_line),
		.data_line     (data_line),
		.busy_res      (busy_res),
		.sequence_end  (sequence_end),
		.start_refused (start_refused),
		.mismatch_count(mismatches),
		.pending_count (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: random stall before each transaction
	initial begin : result_sink
		int hold;
		forever begin
			hold = recv_calm ? 0 : $urandom_range(0, 15);
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
				out_stall = 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
			@(negedge clk);
		end
	end

	function automatic logic [2:0] pick_channel();
		case ($urandom_range(0, 3))
			0:       return 3'd0;
			1:       return 3'd7;
			default: return 3'($urandom_range(0, 7));
		endcase
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic push_item(input logic op_i, input logic [2:0] chan, input logic [7:0] level);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		op          = op_i;
		dac_channel = chan;
		dac_value   = level;
		in_valid    = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic push_tick();
		push_item(OpTick, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_subaddress(input logic [2:0] value);
		drain();
		cfg_write_data = value;
		cfg_write_en   = 1'b1;
		@(negedge clk);
		cfg_write_en = 1'b0;
	endtask

	// one full 88-phase write, with refused starts sprinkled in as ticks
	task automatic run_write(input int refuse_odds);
		int k;
		push_item(OpStart, pick_channel(), pick_level());
		for (k = 1; k < WritePhases; k++) begin
			if ($urandom_range(0, refuse_odds) == 0)
				push_item(OpStart, pick_channel(), pick_level());
			else
				push_tick();
		end
	endtask

	initial begin : stimulus
		int cfg_idx;
		int goal;
		int k;
		logic [2:0] addr_sel;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: idle ticks, a write at reset subaddress, refused starts
		push_item(OpTick, 3'd7, 8'hFF);
		push_item(OpTick, 3'd0, 8'h00);
		push_item(OpStart, 3'd7, 8'hFF);
		push_item(OpStart, 3'd0, 8'h00);
		for (k = 0; k < 8; k++)
			push_tick();
		drain(); // let every result arrive mid-write
		for (k = 0; k < 10; k++)
			push_tick();
		push_item(OpStart, 3'd5, 8'h5A);
		for (k = 21; k < WritePhases - 1; k++)
			push_tick();
		push_item(OpStart, 3'd1, 8'h81); // refused on the final stop phase
		push_item(OpTick, 3'd2, 8'h7E);   // idle again

		for (cfg_idx = 0; cfg_idx < CfgPhases; cfg_idx++) begin
			case (cfg_idx)
				0:       addr_sel = 3'd0;
				1:       addr_sel = 3'd7;
				default: addr_sel = 3'($urandom_range(0, 7));
			endcase
			write_subaddress(addr_sel);
			goal = items_sent + (ItemTarget - items_sent) / (CfgPhases - cfg_idx);
			while (items_sent < goal) begin
				send_calm = ($urandom_range(0, 3) == 0);
				recv_calm = ($urandom_range(0, 3) == 0);
				// occasional noise, which may start a write and misalign the next one
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 6))
						push_item(($urandom_range(0, 3) == 0) ? OpStart : OpTick,
							pick_channel(), pick_level());
				end
				run_write($urandom_range(8, 40));
			end
		end

		drain();
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
